// ===== rtl/core/ddem_pkg.sv =====
// Shared types and constants for the differential drive mixer.
package ddem_pkg;

	// Command and wheel word width, and its fraction bits.
	localparam int DW   = 16;
	localparam int FRAC = DW - 2;

	// Width of an exponential value in Q30, scaled by up to 2^15.
	localparam int EW = 47;

	// Number of series terms and the latency of the exponential unit.
	localparam int TAYLOR_N = 12;
	localparam int EXP_LAT  = 3 + 3 * TAYLOR_N + 1;

	localparam logic [30:0] ONE_Q30   = 31'd1073741824;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30   = 30'd744261118;

	// Configuration range limits.
	localparam logic [15:0] ALPHA_MAX = 16'd40960;
	localparam logic [14:0] GAIN_MIN  = 15'd1639;
	localparam logic [14:0] GAIN_MAX  = 15'd16384;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_SPEED_CURVE_EN = 3'd0,
		REG_SPEED_ALPHA    = 3'd1,
		REG_DIR_CURVE_EN   = 3'd2,
		REG_DIR_ALPHA      = 3'd3,
		REG_SPEED_GAIN     = 3'd4,
		REG_DIR_GAIN       = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [DW-1:0] speed_cmd;
		logic signed [DW-1:0] turn_cmd;
	} cmd_t;

	typedef struct packed {
		logic signed [DW-1:0] left_wheel;
		logic signed [DW-1:0] right_wheel;
		logic                 config_ok;
	} wheel_t;

endpackage

// ===== rtl/core/differential_drive_expo_mixer.sv =====
// Top level of the differential drive mixer with exponential response curves.
//
// Usage: a speed and a turn command arrive as one transfer on the in channel
// (valid/ready); one wheel pair with a config_ok flag leaves on the out
// channel for each. Configuration registers are written through the cfg
// channel, which is always ready, and must only change while no command is
// in flight.
// Throughput is one command pair per cycle unless the receiver stalls.
// The depth is set by the exponential units (three setup stages, three
// stages for each of the twelve series terms and a final shift), the
// fourteen-step restoring divider that normalises the curve, and the gain
// and mixing stages.
// When the receiver stalls, the whole pipeline holds and in_ready falls; no
// transfer is lost or repeated. Reset empties the pipeline and restores the
// register defaults: curves off, exponents 1.0, gains 1.0.
module differential_drive_expo_mixer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ddem_pkg::cmd_t   in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output ddem_pkg::wheel_t out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [15:0]      cfg_data
);
	import ddem_pkg::*;

	localparam int TOTAL = 2 + EXP_LAT + 1 + FRAC + 3;
	localparam int PW    = DW + 16;
	localparam logic signed [DW-1:0] ONE_F  = DW'(2**FRAC);
	localparam logic signed [PW:0]   OUT_HI = (PW+1)'(2**(DW-1) - 1);
	localparam logic signed [PW:0]   OUT_LO = -OUT_HI - (PW+1)'(1);

	logic        speed_en_q, dir_en_q;
	logic [15:0] speed_alpha_q, dir_alpha_q;
	logic [14:0] speed_gain_q, dir_gain_q;
	logic        ok;
	logic        adv;
	logic [TOTAL-1:0] vld_q;

	logic signed [DW-1:0] cmd   [2];
	logic                 en    [2];
	logic [15:0]          alpha [2];
	logic signed [DW-1:0] shaped_s4 [2];

	logic signed [PW-1:0] ps_s5, pd_s5;
	logic signed [PW:0]   lsum, rsum, lq, rq;
	logic signed [DW-1:0] lsat, rsat;
	wheel_t               wheel_s6;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_en_q    <= 1'b0;
			speed_alpha_q <= 16'd4096;
			dir_en_q      <= 1'b0;
			dir_alpha_q   <= 16'd4096;
			speed_gain_q  <= 15'd16384;
			dir_gain_q    <= 15'd16384;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_SPEED_CURVE_EN: speed_en_q    <= cfg_data[0];
				REG_SPEED_ALPHA:    speed_alpha_q <= cfg_data;
				REG_DIR_CURVE_EN:   dir_en_q      <= cfg_data[0];
				REG_DIR_ALPHA:      dir_alpha_q   <= cfg_data;
				REG_SPEED_GAIN:     speed_gain_q  <= cfg_data[14:0];
				REG_DIR_GAIN:       dir_gain_q    <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	assign ok = (speed_alpha_q != 16'd0) && (speed_alpha_q <= ALPHA_MAX)
		&& (dir_alpha_q != 16'd0) && (dir_alpha_q <= ALPHA_MAX)
		&& (speed_gain_q >= GAIN_MIN) && (speed_gain_q <= GAIN_MAX)
		&& (dir_gain_q >= GAIN_MIN) && (dir_gain_q <= GAIN_MAX);

	// Pipeline control: every stage moves together unless the output is held.
	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[TOTAL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[TOTAL-2:0], in_valid};
		end
	end

	assign cmd[0]   = in_data.speed_cmd;
	assign cmd[1]   = in_data.turn_cmd;
	assign en[0]    = speed_en_q;
	assign en[1]    = dir_en_q;
	assign alpha[0] = speed_alpha_q;
	assign alpha[1] = dir_alpha_q;

	// One shaping lane per command.
	for (genvar ln = 0; ln < 2; ln++) begin : g_lane
		logic signed [DW-1:0] v_s1, v_s2;
		logic [FRAC:0]        mag;
		logic [30:0]          x;
		logic [46:0]          tprod;
		logic [30:0]          tn_s2, td_s2;
		logic [EW-1:0]        en_val, ed_val;
		logic signed [DW-1:0] vd [0:EXP_LAT-1];

		logic [EW-1:0]        rem_sd [0:FRAC];
		logic [EW-1:0]        dd_sd  [0:FRAC];
		logic [FRAC:0]        q_sd   [0:FRAC];
		logic signed [DW-1:0] v_sd   [0:FRAC];
		logic                 dz_sd  [0:FRAC];
		logic                 sat_sd [0:FRAC];

		logic [EW:0]          rem2;
		logic [FRAC:0]        qr;
		logic [FRAC:0]        m;
		logic signed [DW-1:0] sh;

		// Clamp to plus or minus one.
		always_ff @(posedge clk) begin
			if (adv) begin
				if (cmd[ln] > ONE_F) begin
					v_s1 <= ONE_F;
				end else if (cmd[ln] < -ONE_F) begin
					v_s1 <= -ONE_F;
				end else begin
					v_s1 <= cmd[ln];
				end
			end
		end

		// Exponent arguments for the value and for full scale.
		assign mag   = v_s1[DW-1] ? (FRAC+1)'(-v_s1) : (FRAC+1)'(v_s1);
		assign x     = 31'(mag) << (30 - FRAC);
		assign tprod = alpha[ln] * x;

		always_ff @(posedge clk) begin
			if (adv) begin
				v_s2  <= v_s1;
				tn_s2 <= tprod[46:16];
				td_s2 <= {1'b0, alpha[ln], 14'b0};
			end
		end

		ddem_exp u_exp_n (
			.clk (clk),
			.adv (adv),
			.t   (tn_s2),
			.e   (en_val)
		);

		ddem_exp u_exp_d (
			.clk (clk),
			.adv (adv),
			.t   (td_s2),
			.e   (ed_val)
		);

		// Carry the clamped command alongside the exponential units.
		always_ff @(posedge clk) begin
			if (adv) begin
				vd[0] <= v_s2;
				for (int i = 1; i < EXP_LAT; i++) begin
					vd[i] <= vd[i-1];
				end
			end
		end

		// Numerator and denominator of the curve.
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sd[0] <= en_val - EW'(ONE_Q30);
				dd_sd[0]  <= ed_val - EW'(ONE_Q30);
				dz_sd[0]  <= (ed_val == EW'(ONE_Q30));
				sat_sd[0] <= (en_val >= ed_val);
				q_sd[0]   <= '0;
				v_sd[0]   <= vd[EXP_LAT-1];
			end
		end

		// Restoring division, one quotient bit per stage.
		for (genvar i = 1; i <= FRAC; i++) begin : g_div
			logic [EW:0] r2;

			assign r2 = {rem_sd[i-1], 1'b0};

			always_ff @(posedge clk) begin
				if (adv) begin
					if (r2 >= {1'b0, dd_sd[i-1]}) begin
						rem_sd[i] <= EW'(r2 - {1'b0, dd_sd[i-1]});
						q_sd[i]   <= {q_sd[i-1][FRAC-1:0], 1'b1};
					end else begin
						rem_sd[i] <= EW'(r2);
						q_sd[i]   <= {q_sd[i-1][FRAC-1:0], 1'b0};
					end
					dd_sd[i]  <= dd_sd[i-1];
					v_sd[i]   <= v_sd[i-1];
					dz_sd[i]  <= dz_sd[i-1];
					sat_sd[i] <= sat_sd[i-1];
				end
			end
		end

		// Round to nearest, limit to one and restore the sign, unless bypassed.
		always_comb begin
			rem2 = {rem_sd[FRAC], 1'b0};
			qr   = q_sd[FRAC] + ((rem2 >= {1'b0, dd_sd[FRAC]}) ? (FRAC+1)'(1) : '0);
			if (sat_sd[FRAC] || qr > (FRAC+1)'(ONE_F)) begin
				m = (FRAC+1)'(ONE_F);
			end else begin
				m = qr;
			end
			if (!en[ln] || dz_sd[FRAC]) begin
				sh = v_sd[FRAC];
			end else if (v_sd[FRAC][DW-1]) begin
				sh = -$signed(DW'(m));
			end else begin
				sh = $signed(DW'(m));
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				shaped_s4[ln] <= sh;
			end
		end
	end

	// Gain products.
	always_ff @(posedge clk) begin
		if (adv) begin
			ps_s5 <= $signed({1'b0, speed_gain_q}) * shaped_s4[0];
			pd_s5 <= $signed({1'b0, dir_gain_q}) * shaped_s4[1];
		end
	end

	// Mix, round to nearest with ties up, and saturate.
	always_comb begin
		lsum = (PW+1)'(ps_s5) + (PW+1)'(pd_s5) + (PW+1)'(8192);
		rsum = (PW+1)'(ps_s5) - (PW+1)'(pd_s5) + (PW+1)'(8192);
		lq   = lsum >>> 14;
		rq   = rsum >>> 14;
		if (lq > OUT_HI) begin
			lsat = DW'(OUT_HI);
		end else if (lq < OUT_LO) begin
			lsat = DW'(OUT_LO);
		end else begin
			lsat = DW'(lq);
		end
		if (rq > OUT_HI) begin
			rsat = DW'(OUT_HI);
		end else if (rq < OUT_LO) begin
			rsat = DW'(OUT_LO);
		end else begin
			rsat = DW'(rq);
		end
	end

	// Output register; an out-of-range configuration forces the wheels to zero.
	always_ff @(posedge clk) begin
		if (adv) begin
			wheel_s6.left_wheel  <= ok ? lsat : '0;
			wheel_s6.right_wheel <= ok ? rsat : '0;
			wheel_s6.config_ok   <= ok;
		end
	end

	assign out_data = wheel_s6;

endmodule

// ===== rtl/core/ddem_exp.sv =====
// Pipelined e^t in Q30 from a Q26 argument, by base-two split and a series.
module ddem_exp (
	input  logic                  clk,
	input  logic                  adv,
	input  logic [30:0]           t,
	output logic [ddem_pkg::EW-1:0] e
);
	import ddem_pkg::*;

	localparam int NS = 3 * TAYLOR_N;

	// Reciprocals floor(2^32 / n) for the series divisions.
	function automatic logic [31:0] recip(input int n);
		logic [31:0] m;
		case (n)
			2:       m = 32'd2147483648;
			3:       m = 32'd1431655765;
			4:       m = 32'd1073741824;
			5:       m = 32'd858993459;
			6:       m = 32'd715827882;
			7:       m = 32'd613566756;
			8:       m = 32'd536870912;
			9:       m = 32'd477218588;
			10:      m = 32'd429496729;
			11:      m = 32'd390451572;
			12:      m = 32'd357913941;
			default: m = 32'd0;
		endcase
		return m;
	endfunction

	logic [45:0] tlo_p_s1;
	logic [46:0] thi_p_s1;
	logic [61:0] u_full;
	logic [31:0] u;
	logic [42:0] flo_p_s2, fhi_p_s2;
	logic [3:0]  k_s2;
	logic [55:0] r_full;

	logic [29:0] r_p   [0:NS];
	logic [3:0]  k_p   [0:NS];
	logic [31:0] sum_p [0:NS];
	logic [30:0] term_p [0:TAYLOR_N];
	logic [60:0] prod_p [1:TAYLOR_N];
	logic [61:0] pm_p   [1:TAYLOR_N];
	logic [29:0] v_p    [1:TAYLOR_N];
	logic [EW-1:0] e_s;

	// Scale by log2(e), split into two partial products.
	always_ff @(posedge clk) begin
		if (adv) begin
			tlo_p_s1 <= t[14:0] * LOG2E_Q30;
			thi_p_s1 <= t[30:15] * LOG2E_Q30;
		end
	end

	assign u_full = {thi_p_s1, 15'b0} + {16'b0, tlo_p_s1};
	assign u      = u_full[61:30];

	// Integer part gives the final shift; the fraction is scaled by ln 2.
	always_ff @(posedge clk) begin
		if (adv) begin
			flo_p_s2 <= u[12:0] * LN2_Q30;
			fhi_p_s2 <= u[25:13] * LN2_Q30;
			k_s2     <= u[29:26];
		end
	end

	assign r_full = {fhi_p_s2, 13'b0} + {13'b0, flo_p_s2};

	always_ff @(posedge clk) begin
		if (adv) begin
			r_p[0]    <= r_full[55:26];
			k_p[0]    <= k_s2;
			sum_p[0]  <= 32'(ONE_Q30);
			term_p[0] <= ONE_Q30;
		end
	end

	// Three stages per series term: multiply, reciprocal multiply, correct.
	for (genvar n = 1; n <= TAYLOR_N; n++) begin : g_term
		localparam logic [31:0] M = recip(n);
		logic [29:0] v_a;
		logic [29:0] q_est;
		logic [29:0] rem;
		logic [29:0] q;

		assign v_a = prod_p[n][59:30];

		always_ff @(posedge clk) begin
			if (adv) begin
				prod_p[n]      <= term_p[n-1] * r_p[3*n-3];
				r_p[3*n-2]     <= r_p[3*n-3];
				k_p[3*n-2]     <= k_p[3*n-3];
				sum_p[3*n-2]   <= sum_p[3*n-3];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pm_p[n]        <= v_a * M;
				v_p[n]         <= v_a;
				r_p[3*n-1]     <= r_p[3*n-2];
				k_p[3*n-1]     <= k_p[3*n-2];
				sum_p[3*n-1]   <= sum_p[3*n-2];
			end
		end

		// The reciprocal estimate is at most one short of the quotient.
		always_comb begin
			q_est = pm_p[n][61:32];
			rem   = v_p[n] - 30'(q_est * 30'(n));
			if (n == 1) begin
				q = v_p[n];
			end else if (rem >= 30'(n)) begin
				q = q_est + 30'd1;
			end else begin
				q = q_est;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				term_p[n]  <= 31'(q);
				sum_p[3*n] <= sum_p[3*n-1] + 32'(q);
				r_p[3*n]   <= r_p[3*n-1];
				k_p[3*n]   <= k_p[3*n-1];
			end
		end
	end

	// Apply the power of two.
	always_ff @(posedge clk) begin
		if (adv) begin
			e_s <= EW'(sum_p[NS]) << k_p[NS];
		end
	end

	assign e = e_s;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the differential drive mixer with exponential curves.
`timescale 1ns / 1ps

module tb;
	import ddem_pkg::*;

	// Write addresses beyond the register list, which the block must ignore.
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam int PIPE_DEPTH  = 60;
	localparam int CYCLE_LIMIT = 600000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	cmd_t       in_data;
	logic       out_valid;
	logic       out_ready;
	wheel_t     out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	differential_drive_expo_mixer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Shadow copy of the configuration registers.
	bit          spd_curve_on;
	bit          dir_curve_on;
	logic [15:0] spd_alpha;
	logic [15:0] dir_alpha;
	logic [14:0] spd_gain;
	logic [14:0] dir_gain;

	wheel_t wheel_queue[$];
	bit     failed;
	bit     idle_on;
	int     hold_len;
	int     cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// e^t with t in Q26, result in Q30, by range reduction and a series.
	function automatic longint unsigned exp_q30(longint unsigned t);
		longint unsigned u, f, r, acc, term;
		int k;
		u = (t * 64'(LOG2E_Q30)) >> 30;
		k = int'((u >> 26) & 64'd31);
		f = u & 64'h3FF_FFFF;
		r = (f * 64'(LN2_Q30)) >> 26;
		acc = 64'(ONE_Q30);
		term = 64'(ONE_Q30);
		for (int n = 1; n <= TAYLOR_N; n++) begin
			term = ((term * r) >> 30) / n;
			acc += term;
		end
		return acc << k;
	endfunction

	// Normalised exponential curve applied to a magnitude of 0 to 1.0.
	function automatic longint unsigned curve_mag(longint unsigned mag, logic [15:0] alpha);
		longint unsigned full, x, num, den, q, rem;
		full = 64'd1 << FRAC;
		x = mag << (30 - FRAC);
		num = exp_q30((64'(alpha) * x) >> 16) - 64'(ONE_Q30);
		den = exp_q30((64'(alpha) * 64'(ONE_Q30)) >> 16) - 64'(ONE_Q30);
		if (den == 0)
			return mag;
		if (num >= den)
			return full;
		q = 0;
		rem = num;
		for (int i = 0; i < FRAC; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				rem -= den;
				q |= 64'd1;
			end
		end
		if (2 * rem >= den)
			q++;
		if (q > full)
			q = full;
		return q;
	endfunction

	// Clamp a command to +/-1.0 and shape it if its curve is on.
	function automatic longint shaped_cmd(logic signed [DW-1:0] raw, bit curve_on,
			logic [15:0] alpha);
		longint v, m;
		v = raw;
		if (v > (1 <<< FRAC))
			v = 1 <<< FRAC;
		if (v < -(1 <<< FRAC))
			v = -(1 <<< FRAC);
		if (!curve_on)
			return v;
		m = longint'(curve_mag(v < 0 ? -v : v, alpha));
		return v < 0 ? -m : m;
	endfunction

	// Round a Q(14+FRAC) sum back to FRAC bits and saturate.
	function automatic logic signed [DW-1:0] wheel_sat(longint sum);
		longint q;
		q = (sum + 8192) >>> 14;
		if (q > (1 <<< (DW - 1)) - 1)
			q = (1 <<< (DW - 1)) - 1;
		if (q < -(1 <<< (DW - 1)))
			q = -(1 <<< (DW - 1));
		return q[DW-1:0];
	endfunction

	function automatic wheel_t mix_wheels(cmd_t c);
		wheel_t w;
		longint s, d, ps, pd;
		w = '0;
		w.config_ok = spd_alpha != 0 && spd_alpha <= ALPHA_MAX
			&& dir_alpha != 0 && dir_alpha <= ALPHA_MAX
			&& spd_gain >= GAIN_MIN && spd_gain <= GAIN_MAX
			&& dir_gain >= GAIN_MIN && dir_gain <= GAIN_MAX;
		if (w.config_ok) begin
			s = shaped_cmd(c.speed_cmd, spd_curve_on, spd_alpha);
			d = shaped_cmd(c.turn_cmd, dir_curve_on, dir_alpha);
			ps = longint'(spd_gain) * s;
			pd = longint'(dir_gain) * d;
			w.left_wheel = wheel_sat(ps + pd);
			w.right_wheel = wheel_sat(ps - pd);
		end
		return w;
	endfunction

	// Record the expected wheel pair for every accepted command transfer.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			wheel_queue.push_back(mix_wheels(in_data));
	end

	// Compare each result transfer with the oldest expectation.
	always @(posedge clk) begin
		wheel_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			if (wheel_queue.size() == 0) begin
				$error("unexpected result transfer");
				failed = 1'b1;
			end else begin
				exp_w = wheel_queue.pop_front();
				if (out_data.left_wheel !== exp_w.left_wheel) begin
					$error("left_wheel expected %0d actual %0d", exp_w.left_wheel,
						out_data.left_wheel);
					failed = 1'b1;
				end
				if (out_data.right_wheel !== exp_w.right_wheel) begin
					$error("right_wheel expected %0d actual %0d", exp_w.right_wheel,
						out_data.right_wheel);
					failed = 1'b1;
				end
				if (out_data.config_ok !== exp_w.config_ok) begin
					$error("config_ok expected %0b actual %0b", exp_w.config_ok,
						out_data.config_ok);
					failed = 1'b1;
				end
			end
		end
	end

	// Receiver: random stalls per transfer, with an occasional long hold-off.
	initial begin
		int w;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_len > 0) begin
				out_ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else begin
				w = idle_on ? $urandom_range(0, 8) : 0;
				if (w > 0) begin
					out_ready <= 1'b0;
					repeat (w) @(posedge clk);
				end
				out_ready <= 1'b1;
				do @(posedge clk);
				while (!(out_valid && out_ready) && hold_len == 0);
			end
		end
	end

	// Offer one command pair and wait for its transfer.
	task automatic send_cmd(cmd_t c);
		int gap;
		gap = idle_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= c;
		do @(posedge clk);
		while (!(in_valid && in_ready));
	endtask

	task automatic send_pair(int s, int t);
		cmd_t c;
		c.speed_cmd = s[DW-1:0];
		c.turn_cmd = t[DW-1:0];
		send_cmd(c);
	endtask

	// Let the pipeline drain before touching a register.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (wheel_queue.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!(cfg_valid && cfg_ready));
		case (idx)
			REG_SPEED_CURVE_EN: spd_curve_on = val[0];
			REG_SPEED_ALPHA:    spd_alpha = val;
			REG_DIR_CURVE_EN:   dir_curve_on = val[0];
			REG_DIR_ALPHA:      dir_alpha = val;
			REG_SPEED_GAIN:     spd_gain = val[14:0];
			REG_DIR_GAIN:       dir_gain = val[14:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(int s_on, int s_a, int d_on, int d_a, int s_g, int d_g);
		drain();
		write_reg(REG_SPEED_CURVE_EN, {15'($urandom_range(0, 32767)), s_on[0]});
		write_reg(REG_SPEED_ALPHA, s_a[15:0]);
		write_reg(REG_DIR_CURVE_EN, {15'($urandom_range(0, 32767)), d_on[0]});
		write_reg(REG_DIR_ALPHA, d_a[15:0]);
		write_reg(REG_SPEED_GAIN, {1'($urandom_range(0, 1)), s_g[14:0]});
		write_reg(REG_DIR_GAIN, {1'($urandom_range(0, 1)), d_g[14:0]});
	endtask

	// Commands that hit the clamp edges, zero and the extremes of the word.
	task automatic send_corner_cmds();
		int vals[7] = '{-32768, -16385, -16384, 0, 1, 16384, 32767};
		foreach (vals[i])
			send_pair(vals[i], vals[(i + 3) % 7]);
	endtask

	task automatic send_random_cmd();
		if ($urandom_range(0, 3) == 0)
			send_pair($urandom_range(0, 65535), $urandom_range(0, 65535));
		else
			send_pair($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
	endtask

	// Default registers straight after reset.
	task automatic test_reset_defaults();
		send_corner_cmds();
		send_pair(8192, -4096);
	endtask

	// Both curves at the extreme exponents and gains, then out-of-range settings.
	task automatic test_curve_extremes();
		set_config(1, 1, 1, 40960, 1639, 16384);
		send_corner_cmds();
		send_pair(3, -2);
		set_config(1, 40960, 1, 1, 16384, 1639);
		send_corner_cmds();
		set_config(1, 0, 0, 4096, 16384, 16384);
		send_pair(16384, 16384);
		set_config(0, 40961, 1, 65535, 1638, 32767);
		send_pair(-16384, 100);
		set_config(1, 4096, 1, 4096, 16385, 16384);
		send_pair(16384, -16384);
		// Writes to spare addresses must leave every register as it was.
		drain();
		write_reg(REG_SPARE_LO, 16'h0000);
		write_reg(REG_SPARE_HI, 16'hFFFF);
		send_pair(12000, -9000);
	endtask

	task automatic test_random_phases(int phases, int per_phase);
		for (int p = 0; p < phases; p++) begin
			idle_on = (p % 4) != 3;
			if ($urandom_range(0, 4) == 0)
				set_config($urandom_range(0, 1), $urandom_range(0, 65535),
					$urandom_range(0, 1), $urandom_range(0, 65535),
					$urandom_range(0, 32767), $urandom_range(0, 32767));
			else
				set_config($urandom_range(0, 1), $urandom_range(1, 40960),
					$urandom_range(0, 1), $urandom_range(1, 40960),
					$urandom_range(1639, 16384), $urandom_range(1639, 16384));
			for (int i = 0; i < per_phase; i++)
				send_random_cmd();
		end
		idle_on = 1'b1;
	endtask

	// Receiver holds off for a long stretch while commands keep coming.
	task automatic test_output_backpressure();
		set_config(1, 20000, 1, 30000, 12000, 9000);
		hold_len = 400;
		for (int i = 0; i < 150; i++)
			send_random_cmd();
	endtask

	// Sender stops until every result is in, then carries on.
	task automatic test_sender_pause();
		for (int i = 0; i < 40; i++)
			send_random_cmd();
		in_valid <= 1'b0;
		@(posedge clk);
		while (wheel_queue.size() != 0)
			@(posedge clk);
		for (int i = 0; i < 40; i++)
			send_random_cmd();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		failed = 1'b0;
		idle_on = 1'b1;
		hold_len = 0;
		cycles = 0;
		spd_curve_on = 1'b0;
		dir_curve_on = 1'b0;
		spd_alpha = 16'd4096;
		dir_alpha = 16'd4096;
		spd_gain = 15'd16384;
		dir_gain = 15'd16384;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_curve_extremes();
		test_random_phases(20, 60);
		test_output_backpressure();
		test_sender_pause();

		in_valid <= 1'b0;
		@(posedge clk);
		while (wheel_queue.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 20) @(posedge clk);
		if (wheel_queue.size() != 0) begin
			$error("%0d expected results never arrived", wheel_queue.size());
			failed = 1'b1;
		end
		if (!failed)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/ddem_pkg.sv
rtl/core/ddem_exp.sv
rtl/core/differential_drive_expo_mixer.sv
dv/tb.sv
